FILE: src/swarq_pkg.sv
// ----------------------------------------------------------------------------
// swarq_pkg
// Shared types, codes and constants of the stop-and-wait ARQ sender.
// ----------------------------------------------------------------------------
package swarq_pkg;

  // field widths
  localparam int SEQ_BITS   = 32;
  localparam int MSG_W      = 32;
  localparam int FUNC_W     = 2;
  localparam int KIND_W     = 8;
  localparam int EVT_W      = 2;
  localparam int ATT_W      = 3;
  localparam int WAIT_W     = 23;
  localparam int BASE_W     = 16;
  localparam int RETRY_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // item kinds
  localparam logic [FUNC_W-1:0] FUNC_NEW   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REPLY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

  // result codes
  localparam logic [EVT_W-1:0] EV_TX        = 2'd0;
  localparam logic [EVT_W-1:0] EV_DELIVERED = 2'd1;
  localparam logic [EVT_W-1:0] EV_FAILED    = 2'd2;
  localparam logic [EVT_W-1:0] EV_REJECTED  = 2'd3;

  // reply kind that acknowledges
  localparam logic [KIND_W-1:0] KIND_ACK = 8'd1;

  // attempt limit saturation
  localparam logic [RETRY_W-1:0] TRY_CAP = 4'd8;
  localparam logic [RETRY_W-1:0] TRY_MIN = 4'd1;

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES  = 1'd1;
  localparam logic [BASE_W-1:0]    BASE_RESET       = 16'd500;
  localparam logic [RETRY_W-1:0]   RETRY_RESET      = 4'd5;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [MSG_W-1:0]  msg_seq;
    logic [KIND_W-1:0] reply_kind;
    logic [MSG_W-1:0]  reply_seq;
  } item_t;

  typedef struct packed {
    logic [EVT_W-1:0]  event_res;
    logic [MSG_W-1:0]  event_seq;
    logic [ATT_W-1:0]  attempt;
    logic [WAIT_W-1:0] wait_ticks;
  } res_t;

  typedef struct packed {
    logic                busy;
    logic [SEQ_BITS-1:0] pending_seq;
    logic [ATT_W-1:0]    attempt_count;
    logic [WAIT_W-1:0]   timer;
  } state_t;

  typedef struct packed {
    logic [BASE_W-1:0]  base_timeout_ticks;
    logic [RETRY_W-1:0] try_limit;
  } cfg_t;

  // timeout for an attempt: base shifted left by the attempt number
  function automatic logic [WAIT_W-1:0] attempt_wait(input logic [BASE_W-1:0] base,
                                                     input logic [ATT_W-1:0] att);
    logic [WAIT_W-1:0] w;
    w = WAIT_W'(base) << att;
    return w;
  endfunction

endpackage

FILE: src/swarq_in_if.sv
// ----------------------------------------------------------------------------
// swarq_in_if
// Input channel: one word per event (new message, reply or timer tick).
// ----------------------------------------------------------------------------
interface swarq_in_if;
  import swarq_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [MSG_W-1:0]  msg_seq;
  logic [KIND_W-1:0] reply_kind;
  logic [MSG_W-1:0]  reply_seq;

  modport source (output valid, func, msg_seq, reply_kind, reply_seq, input ready);
  modport sink   (input valid, func, msg_seq, reply_kind, reply_seq, output ready);
endinterface

FILE: src/swarq_out_if.sv
// ----------------------------------------------------------------------------
// swarq_out_if
// Output channel: one word per sender event (transmit, delivered, failed,
// rejected).
// ----------------------------------------------------------------------------
interface swarq_out_if;
  import swarq_pkg::*;

  logic              valid;
  logic              ready;
  logic [EVT_W-1:0]  event_res;
  logic [MSG_W-1:0]  event_seq;
  logic [ATT_W-1:0]  attempt;
  logic [WAIT_W-1:0] wait_ticks;

  modport source (output valid, event_res, event_seq, attempt, wait_ticks, input ready);
  modport sink   (input valid, event_res, event_seq, attempt, wait_ticks, output ready);
endinterface

FILE: src/swarq_step.sv
// ----------------------------------------------------------------------------
// swarq_step
// Per-word decision logic: next sender state and the optional result word.
// ----------------------------------------------------------------------------
module swarq_step import swarq_pkg::*; (
  input  item_t  item,
  input  state_t cur,
  input  cfg_t   cfg,
  output state_t nxt,
  output res_t   res,
  output logic   has_res
);

  logic [RETRY_W-1:0] limit;
  logic [RETRY_W-1:0] next_att;
  logic               last_try;
  logic               ack_match;
  logic               over;

  // effective attempt limit, saturated to one..eight
  always_comb begin
    if (cfg.try_limit == '0) begin
      limit = TRY_MIN;
    end else if (cfg.try_limit > TRY_CAP) begin
      limit = TRY_CAP;
    end else begin
      limit = cfg.try_limit;
    end
  end

  assign next_att  = RETRY_W'(cur.attempt_count) + RETRY_W'(1);
  assign last_try  = (next_att >= limit);
  assign ack_match = (item.reply_kind == KIND_ACK) &&
                     (item.reply_seq[SEQ_BITS-1:0] == cur.pending_seq);

  // event handling
  always_comb begin
    nxt     = cur;
    res     = '0;
    has_res = 1'b0;
    over    = 1'b0;
    case (item.func)
      FUNC_NEW: begin
        has_res = 1'b1;
        if (cur.busy) begin
          res.event_res = EV_REJECTED;
          res.event_seq = MSG_W'(item.msg_seq[SEQ_BITS-1:0]);
        end else begin
          nxt.busy          = 1'b1;
          nxt.pending_seq   = item.msg_seq[SEQ_BITS-1:0];
          nxt.attempt_count = '0;
          nxt.timer         = attempt_wait(cfg.base_timeout_ticks, '0);
          res.event_res     = EV_TX;
          res.event_seq     = MSG_W'(item.msg_seq[SEQ_BITS-1:0]);
          res.wait_ticks    = nxt.timer;
        end
      end
      FUNC_REPLY: begin
        if (cur.busy) begin
          if (ack_match) begin
            nxt.busy      = 1'b0;
            nxt.timer     = '0;
            has_res       = 1'b1;
            res.event_res = EV_DELIVERED;
            res.event_seq = MSG_W'(cur.pending_seq);
            res.attempt   = cur.attempt_count;
          end else begin
            over = 1'b1;
          end
        end
      end
      FUNC_TICK: begin
        if (cur.busy) begin
          if (cur.timer <= WAIT_W'(1)) begin
            over = 1'b1;
          end else begin
            nxt.timer = cur.timer - WAIT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase

    // attempt ended: retransmit or give up
    if (over) begin
      has_res       = 1'b1;
      res.event_seq = MSG_W'(cur.pending_seq);
      if (last_try) begin
        nxt.busy      = 1'b0;
        nxt.timer     = '0;
        res.event_res = EV_FAILED;
        res.attempt   = cur.attempt_count;
      end else begin
        nxt.attempt_count = next_att[ATT_W-1:0];
        nxt.timer         = attempt_wait(cfg.base_timeout_ticks, next_att[ATT_W-1:0]);
        res.event_res     = EV_TX;
        res.attempt       = next_att[ATT_W-1:0];
        res.wait_ticks    = nxt.timer;
      end
    end
  end

endmodule

FILE: src/stop_wait_arq_sender.sv
// ----------------------------------------------------------------------------
// stop_wait_arq_sender
// Sender side of a stop-and-wait ARQ with exponential retransmit backoff.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word per event: a new message to send, a reply seen on
//   the link, or a timer tick. rsp carries the sender's events: transmit
//   command (with attempt number and loaded timeout), delivered, failed
//   after the retry limit, or rejected because a transfer is in progress.
//   Ticks and replies while idle produce no word.
//   cfg_we / cfg_index / cfg_data write base_timeout_ticks (index 0) and
//   the attempt limit (index 1); write them only while the sender is idle.
// Timing:
//   a word accepted on req is held in the input register; its result is
//   then registered in the output register, which drives rsp.valid. One
//   word per cycle is sustained while rsp is not stalled: the input register
//   and the output register each advance every cycle.
// Reset:
//   rst (synchronous) empties both registers, returns the sender to idle and
//   loads the registers with 500 ticks and 5 attempts.
// Stall:
//   while rsp is held, the output register keeps its word; the input
//   register still drains words that give no result, and req.ready drops
//   only once a word that needs the output register is waiting.
// ----------------------------------------------------------------------------
module stop_wait_arq_sender import swarq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  swarq_in_if.sink              req,
  swarq_out_if.source           rsp
);

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  logic   stg_valid;
  item_t  stg_item;
  logic   out_valid;
  res_t   out_word;
  res_t   res;
  logic   has_res;
  logic   out_free;
  logic   advance;
  logic   take;

  // decision logic
  swarq_step u_step (
    .item    (stg_item),
    .cur     (st),
    .cfg     (cfg),
    .nxt     (st_next),
    .res     (res),
    .has_res (has_res)
  );

  // handshake
  assign out_free  = !out_valid || rsp.ready;
  assign advance   = stg_valid && (!has_res || out_free);
  assign req.ready = !stg_valid || advance;
  assign take      = req.valid && req.ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_timeout_ticks <= BASE_RESET;
      cfg.try_limit          <= RETRY_RESET;
      st                     <= '0;
      stg_valid              <= 1'b0;
      out_valid              <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_TIMEOUT: cfg.base_timeout_ticks <= cfg_data[BASE_W-1:0];
          CFG_MAX_RETRIES:  cfg.try_limit          <= cfg_data[RETRY_W-1:0];
          default: begin
          end
        endcase
      end
      if (take) begin
        stg_valid <= 1'b1;
      end else if (advance) begin
        stg_valid <= 1'b0;
      end
      if (advance) begin
        st <= st_next;
      end
      if (advance && has_res) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      stg_item.func       <= req.func;
      stg_item.msg_seq    <= req.msg_seq;
      stg_item.reply_kind <= req.reply_kind;
      stg_item.reply_seq  <= req.reply_seq;
    end
    if (advance && has_res) begin
      out_word <= res;
    end
  end

  // output channel
  assign rsp.valid      = out_valid;
  assign rsp.event_res  = out_word.event_res;
  assign rsp.event_seq  = out_word.event_seq;
  assign rsp.attempt    = out_word.attempt;
  assign rsp.wait_ticks = out_word.wait_ticks;

endmodule

FILE: src/swarq_checker.sv
// ----------------------------------------------------------------------------
// swarq_assert
// Port-level checks on the sender's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module swarq_assert import swarq_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [EVT_W-1:0]  event_res,
  input logic [MSG_W-1:0]  event_seq,
  input logic [ATT_W-1:0]  attempt,
  input logic [WAIT_W-1:0] wait_ticks
);

  // no word right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result word present after reset");

  // a stalled word stays
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result word dropped while stalled");

  // a stalled word keeps its sequence number
  a_hold_seq: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(event_seq))
    else $error("result sequence changed while stalled");

  // only a transmit carries a timeout
  a_wait_tx_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (event_res != EV_TX) |-> (wait_ticks == '0))
    else $error("timeout on a non-transmit word");

  // a rejected message reports attempt zero
  a_reject_att: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (event_res == EV_REJECTED) |-> (attempt == '0))
    else $error("rejected word with nonzero attempt");

endmodule

bind stop_wait_arq_sender swarq_assert u_swarq_assert (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .event_res  (rsp.event_res),
  .event_seq  (rsp.event_seq),
  .attempt    (rsp.attempt),
  .wait_ticks (rsp.wait_ticks)
);

FILE: test/swarq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarq_checker
// Watches the request, result and register-write ports of the ARQ sender,
// keeps its own copy of the sender state, predicts the event for every
// accepted word and compares each result word field by field in order.
// ----------------------------------------------------------------------------
module swarq_checker import swarq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  swarq_in_if                   req,
  swarq_out_if                  rsp,
  output int                    errors,
  output int                    pending
);

  // shadow of the sender state and its registers
  logic                busy_q;
  logic [SEQ_BITS-1:0] pend_seq;
  logic [ATT_W-1:0]    try_q;
  logic [WAIT_W-1:0]   timer_q;
  logic [BASE_W-1:0]   base_q;
  logic [RETRY_W-1:0]  retries_q;

  // events still owed by the sender, oldest first
  res_t expected_events[$];

  task automatic report(input string msg);
    if (errors < 100) $display("%0t ns  mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic res_t make_event(input logic [EVT_W-1:0] code,
                                      input logic [MSG_W-1:0] seq,
                                      input logic [ATT_W-1:0] att,
                                      input logic [WAIT_W-1:0] ticks);
    res_t ev;
    ev.event_res  = code;
    ev.event_seq  = seq;
    ev.attempt    = att;
    ev.wait_ticks = ticks;
    return ev;
  endfunction

  // new attempt: timer is base doubled once per earlier attempt
  function automatic res_t load_attempt(input logic [ATT_W-1:0] att);
    try_q   = att;
    timer_q = {{(WAIT_W-BASE_W){1'b0}}, base_q} << att;
    return make_event(EV_TX, MSG_W'(pend_seq), try_q, timer_q);
  endfunction

  // current attempt lost: retransmit, or give up at the retry limit
  function automatic res_t end_attempt();
    logic [RETRY_W-1:0] lim;
    logic [RETRY_W-1:0] nxt;
    lim = (retries_q > TRY_CAP) ? TRY_CAP : retries_q;
    nxt = {1'b0, try_q} + 1'b1;
    if (nxt >= lim) begin
      busy_q  = 1'b0;
      timer_q = '0;
      return make_event(EV_FAILED, MSG_W'(pend_seq), try_q, '0);
    end
    return load_attempt(nxt[ATT_W-1:0]);
  endfunction

  // one input word; returns 1 when it causes an event
  function automatic bit arq_step(input item_t w, output res_t ev);
    ev = '0;
    case (w.func)
      FUNC_NEW: begin
        if (busy_q) begin
          ev = make_event(EV_REJECTED, MSG_W'(w.msg_seq[SEQ_BITS-1:0]), '0, '0);
          return 1'b1;
        end
        busy_q   = 1'b1;
        pend_seq = w.msg_seq[SEQ_BITS-1:0];
        ev = load_attempt('0);
        return 1'b1;
      end
      FUNC_REPLY: begin
        if (!busy_q) return 1'b0;
        if (w.reply_kind == KIND_ACK && w.reply_seq[SEQ_BITS-1:0] == pend_seq) begin
          busy_q  = 1'b0;
          timer_q = '0;
          ev = make_event(EV_DELIVERED, MSG_W'(pend_seq), try_q, '0);
          return 1'b1;
        end
        ev = end_attempt();
        return 1'b1;
      end
      FUNC_TICK: begin
        if (!busy_q) return 1'b0;
        if (timer_q <= 1) begin
          timer_q = '0;
          ev = end_attempt();
          return 1'b1;
        end
        timer_q = timer_q - 1'b1;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // register writes, prediction on accept, compare on result
  always @(posedge clk) begin
    item_t w;
    res_t  got;
    res_t  want;
    res_t  ev;
    if (rst) begin
      busy_q    = 1'b0;
      pend_seq  = '0;
      try_q     = '0;
      timer_q   = '0;
      base_q    = BASE_RESET;
      retries_q = RETRY_RESET;
      expected_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_TIMEOUT: base_q    = cfg_data[BASE_W-1:0];
          CFG_MAX_RETRIES:  retries_q = cfg_data[RETRY_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        w.func       = req.func;
        w.msg_seq    = req.msg_seq;
        w.reply_kind = req.reply_kind;
        w.reply_seq  = req.reply_seq;
        if (arq_step(w, ev)) expected_events.push_back(ev);
      end
      if (rsp.valid && rsp.ready) begin
        got = make_event(rsp.event_res, rsp.event_seq, rsp.attempt, rsp.wait_ticks);
        if (expected_events.size() == 0) begin
          report($sformatf("unexpected word res=%0d seq=%h", got.event_res, got.event_seq));
        end else begin
          want = expected_events.pop_front();
          if (got.event_res !== want.event_res)
            report($sformatf("event_res got %0d want %0d", got.event_res, want.event_res));
          if (got.event_seq !== want.event_seq)
            report($sformatf("event_seq got %h want %h", got.event_seq, want.event_seq));
          if (got.attempt !== want.attempt)
            report($sformatf("attempt got %0d want %0d", got.attempt, want.attempt));
          if (got.wait_ticks !== want.wait_ticks)
            report($sformatf("wait_ticks got %0d want %0d", got.wait_ticks, want.wait_ticks));
        end
      end
    end
    pending <= expected_events.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the stop-and-wait ARQ sender with directed corner words and then
// random transfers under several register settings, with bursty requests and
// a stalling result port; the checker predicts and compares every event.
// ----------------------------------------------------------------------------
module testbench;
  import swarq_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [KIND_W-1:0] KIND_NAK    = 8'd2;
  localparam int PHASE_WORDS = 290;
  localparam int NUM_PHASES  = 6;
  localparam int IDLE_LIMIT  = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  swarq_in_if  req_ch ();
  swarq_out_if rsp_ch ();

  int fail_count;
  int pending_count;
  int words_sent;
  int burst_left;
  bit holding;
  int idle_cycles;
  int stall_mode;
  int mode_left;
  int cyc;

  // register settings per phase, extremes included
  int base_set[NUM_PHASES]  = '{1, 0, 65535, 3, 2, 6};
  int retry_set[NUM_PHASES] = '{8, 0, 8, 15, 1, 4};

  stop_wait_arq_sender DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  swarq_checker CHK (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .errors    (fail_count),
    .pending   (pending_count)
  );

  always #10 clk = ~clk;

  // result port stalls, in a pattern picked at random from four
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(16, 80);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= 1'($urandom_range(0, 1));
      2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      default: rsp_ch.ready <= (cyc % 4 != 3);
    endcase
  end

  // watchdog: too long without any word moving
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic item_t mk_word(input logic [FUNC_W-1:0] f, input logic [MSG_W-1:0] m,
                                    input logic [KIND_W-1:0] k, input logic [MSG_W-1:0] r);
    item_t w;
    w.func       = f;
    w.msg_seq    = m;
    w.reply_kind = k;
    w.reply_seq  = r;
    return w;
  endfunction

  // present one word, hold until accepted, then maybe close the burst
  task automatic put_word(input item_t w);
    req_ch.valid      <= 1'b1;
    req_ch.func       <= w.func;
    req_ch.msg_seq    <= w.msg_seq;
    req_ch.reply_kind <= w.reply_kind;
    req_ch.reply_seq  <= w.reply_seq;
    holding = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (w.func != FUNC_UNUSED) words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_ch.valid <= 1'b0;
      holding = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // enough NAKs to exhaust any retry limit
  task automatic abandon_transfer(input logic [MSG_W-1:0] seq);
    repeat (TRY_CAP) put_word(mk_word(FUNC_REPLY, $urandom, KIND_NAK, seq));
  endtask

  // one well-formed transfer with random trouble along the way
  task automatic run_transfer();
    logic [MSG_W-1:0] s;
    logic [MSG_W-1:0] rs;
    s = $urandom;
    put_word(mk_word(FUNC_NEW, s, KIND_W'($urandom), $urandom));
    repeat ($urandom_range(0, 6)) begin
      rs = ($urandom_range(0, 1) == 1) ? s : $urandom;
      case ($urandom_range(0, 6))
        0: repeat ($urandom_range(1, 12))
             put_word(mk_word(FUNC_TICK, $urandom, KIND_W'($urandom), $urandom));
        1: put_word(mk_word(FUNC_REPLY, $urandom, KIND_NAK, rs));
        2: put_word(mk_word(FUNC_REPLY, $urandom, KIND_W'($urandom), rs));
        3: put_word(mk_word(FUNC_REPLY, $urandom, KIND_ACK, s ^ (32'd1 << $urandom_range(0, 31))));
        4: put_word(mk_word(FUNC_NEW, s, KIND_W'($urandom), $urandom));
        5: if ($urandom_range(0, 3) == 0) put_word(mk_word(FUNC_REPLY, $urandom, KIND_ACK, s));
        default: put_word(mk_word(FUNC_UNUSED, $urandom, KIND_W'($urandom), $urandom));
      endcase
    end
    if ($urandom_range(0, 9) < 7) put_word(mk_word(FUNC_REPLY, $urandom, KIND_ACK, s));
    else abandon_transfer(s);
  endtask

  // fully random words, then force the sender back to idle
  task automatic noise_burst();
    repeat ($urandom_range(3, 15))
      put_word(mk_word(FUNC_W'($urandom_range(0, 3)), $urandom, KIND_W'($urandom), $urandom));
    abandon_transfer($urandom);
  endtask

  // stop sending and wait until every owed event has arrived
  task automatic settle();
    if (holding) begin
      req_ch.valid <= 1'b0;
      holding = 1'b0;
    end
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [BASE_W-1:0] base, input logic [RETRY_W-1:0] tries);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE_TIMEOUT;
    cfg_data  <= CFG_DATA_W'(base);
    @(posedge clk);
    cfg_index <= CFG_MAX_RETRIES;
    cfg_data  <= CFG_DATA_W'(tries);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int target;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_BASE_TIMEOUT;
    cfg_data          <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.func       <= FUNC_TICK;
    req_ch.msg_seq    <= '0;
    req_ch.reply_kind <= '0;
    req_ch.reply_seq  <= '0;
    words_sent = 0;
    burst_left = 0;
    holding    = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed words at the reset settings
    put_word(mk_word(FUNC_TICK, '1, '1, '1));              // tick while idle
    put_word(mk_word(FUNC_REPLY, '0, KIND_ACK, '0));       // reply while idle
    put_word(mk_word(FUNC_UNUSED, '1, '1, '1));            // unused kind
    put_word(mk_word(FUNC_NEW, '1, '0, '0));               // start, all-ones seq
    put_word(mk_word(FUNC_NEW, '0, '1, '1));               // rejected while busy
    put_word(mk_word(FUNC_UNUSED, '0, '0, '0));            // unused kind while busy
    put_word(mk_word(FUNC_REPLY, '0, 8'hFF, '1));          // data reply, matching seq
    put_word(mk_word(FUNC_REPLY, '1, KIND_ACK, '0));       // ack for wrong seq
    put_word(mk_word(FUNC_TICK, '0, '0, '0));              // plain countdown
    put_word(mk_word(FUNC_REPLY, '0, KIND_NAK, '1));       // nak
    put_word(mk_word(FUNC_REPLY, '0, 8'h00, '1));          // data reply kind zero
    put_word(mk_word(FUNC_REPLY, '0, KIND_NAK, '1));       // retry limit, failed
    put_word(mk_word(FUNC_TICK, '0, '0, '0));              // idle again
    put_word(mk_word(FUNC_NEW, '0, '1, '1));               // start, zero seq
    put_word(mk_word(FUNC_REPLY, '1, KIND_ACK, '0));       // delivered on first try
    put_word(mk_word(FUNC_NEW, 32'hA5A5_5A5A, '0, '0));
    put_word(mk_word(FUNC_REPLY, '0, KIND_ACK, 32'hA5A5_5A5A));

    // random transfers under each register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_config(BASE_W'(base_set[p]), RETRY_W'(retry_set[p]));
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        if ($urandom_range(0, 9) == 0) noise_burst();
        else run_transfer();
      end
      abandon_transfer($urandom);
    end

    settle();
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
